// ----- sv/magnetic_dipole_field_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dipole field block
// Clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAGNETIC_DIPOLE_FIELD_TOP_ASSERT_SVH
`define MAGNETIC_DIPOLE_FIELD_TOP_ASSERT_SVH

// same-cycle implication
`define MDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MDF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mdf_pkg.sv -----
// ----------------------------------------------------------------------------
// mdf_pkg
// Types and constants shared by the dipole field block.
// ----------------------------------------------------------------------------
package mdf_pkg;

    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;
    localparam int SQ_STEPS   = 32;
    localparam int UDIV_STEPS = 30;
    localparam int FDIV_STEPS = 41;
    // A, B, C, sqrt, D, u divide, E..K, L, f divide, output
    localparam int LAT = 3 + SQ_STEPS + 1 + UDIV_STEPS + 7 + 1 + FDIV_STEPS + 1;

    localparam logic [43:0] MEGA          = 44'd1000000;
    localparam logic [39:0] FIELD_POS_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] FIELD_NEG_MAG = 40'h80_0000_0000;

    typedef struct packed {
        logic signed [23:0] magnet_x;
        logic signed [23:0] magnet_y;
        logic signed [23:0] magnet_z;
        logic        [23:0] moment;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [23:0] sensor_x;
        logic signed [23:0] sensor_y;
        logic signed [23:0] sensor_z;
    } t_in_item;

    typedef struct packed {
        logic signed [39:0] field_x;
        logic signed [39:0] field_y;
        logic signed [39:0] field_z;
        logic               too_close;
    } t_out_item;

    typedef struct packed {
        logic            close;
        logic [23:0]     moment;
        logic [2:0][15:0] dir;
    } t_ctx;

    typedef struct packed {
        logic [2:0][24:0] p;
        t_ctx             ctx;
    } t_job;

endpackage

// ----- sv/magnetic_dipole_field_top.sv -----
// ----------------------------------------------------------------------------
// magnetic_dipole_field_top
// Dipole field of one magnet at one sensor, Q32.8 per axis.
// ----------------------------------------------------------------------------
// Input channel: drive i_item and push; the item is taken on a clock edge with
// push high and full low. Output channel: while empty is low, o_item holds
// the oldest result; it is taken on an edge with pop high.
// Throughput: one item per cycle while the output is not stalled, set by the
// fully pipelined square root (32 stages), unit vector divider (30 stages)
// and rounding divider (41 stages), each resolving one bit per stage.
// Coincident magnet and sensor give too_close set and all fields zero.
// While a result waits with pop low the back pipeline holds in place and a
// four-entry queue behind the front takes items; full rises once it fills.
// Reset (synchronous, i_rst_n low) empties the queue and the pipeline.
// ----------------------------------------------------------------------------
module magnetic_dipole_field_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mdf_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output mdf_pkg::t_out_item o_item
);

    mdf_pkg::t_job front_job;
    mdf_pkg::t_job q_job;
    logic          q_empty;
    logic          q_pop;

    mdf_front u_front (
        .i_item (i_item),
        .o_job  (front_job)
    );

    mdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    mdf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_job     (q_job),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule

// ----- sv/mdf_front.sv -----
// ----------------------------------------------------------------------------
// mdf_front
// Forms the magnet-to-sensor offset and flags coincident positions.
// ----------------------------------------------------------------------------
module mdf_front (
    input  mdf_pkg::t_in_item i_item,
    output mdf_pkg::t_job     o_job
);

    logic [24:0] p_x;
    logic [24:0] p_y;
    logic [24:0] p_z;

    assign p_x = {i_item.magnet_x[23], i_item.magnet_x} - {i_item.sensor_x[23], i_item.sensor_x};
    assign p_y = {i_item.magnet_y[23], i_item.magnet_y} - {i_item.sensor_y[23], i_item.sensor_y};
    assign p_z = {i_item.magnet_z[23], i_item.magnet_z} - {i_item.sensor_z[23], i_item.sensor_z};

    always_comb begin
        o_job.p[0]       = p_x;
        o_job.p[1]       = p_y;
        o_job.p[2]       = p_z;
        o_job.ctx.close  = (p_x == '0) && (p_y == '0) && (p_z == '0);
        o_job.ctx.moment = i_item.moment;
        o_job.ctx.dir[0] = i_item.dir_x;
        o_job.ctx.dir[1] = i_item.dir_y;
        o_job.ctx.dir[2] = i_item.dir_z;
    end

endmodule

// ----- sv/mdf_queue.sv -----
// ----------------------------------------------------------------------------
// mdf_queue
// Short queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module mdf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mdf_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mdf_pkg::t_job  o_data
);

    mdf_pkg::t_job              r_mem [mdf_pkg::QDEPTH];
    logic [mdf_pkg::QAW-1:0]    r_wp;
    logic [mdf_pkg::QAW-1:0]    r_rp;
    logic [mdf_pkg::QAW:0]      r_cnt;
    logic [mdf_pkg::QAW:0]      n_cnt;
    logic                       wr;
    logic                       rd;

    assign o_full  = (r_cnt == (mdf_pkg::QAW+1)'(mdf_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- sv/mdf_back.sv -----
// ----------------------------------------------------------------------------
// mdf_back
// Field pipeline: square root, unit vector divide, dot product, scaling and
// the final rounding divide, one item per stage, held as a whole on stall.
// ----------------------------------------------------------------------------
module mdf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  mdf_pkg::t_job      i_job,
    output logic               o_empty,
    input  logic               i_pop,
    output mdf_pkg::t_out_item o_item
);

    localparam int L  = mdf_pkg::LAT;
    localparam int SQ = mdf_pkg::SQ_STEPS;
    localparam int U  = mdf_pkg::UDIV_STEPS;
    localparam int F  = mdf_pkg::FDIV_STEPS;

    logic          en;
    logic          take;
    logic [L-1:0]  r_vld;

    assign en      = !r_vld[L-1] || i_pop;
    assign take    = en && !i_q_empty;
    assign o_q_pop = take;
    assign o_empty = !r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], take};
        end
    end

    // ---- offset squares and sum
    mdf_pkg::t_job       r_a_job;
    mdf_pkg::t_job       r_b_job;
    logic [2:0][47:0]    r_b_sq;
    logic signed [49:0]  sq_full [3];
    logic [49:0]         sq_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_full[i] = $signed(r_a_job.p[i]) * $signed(r_a_job.p[i]);
        end
        sq_sum = 50'(r_b_sq[0]) + 50'(r_b_sq[1]) + 50'(r_b_sq[2]);
    end

    // ---- square root, one result bit per stage
    logic [63:0]         r_sx [0:SQ];
    logic [63:0]         r_sr [0:SQ];
    mdf_pkg::t_job       r_sj [0:SQ];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_job <= i_job;
            r_b_job <= r_a_job;
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i] <= sq_full[i][47:0];
            end
            r_sx[0] <= {sq_sum, 14'd0};
            r_sr[0] <= '0;
            r_sj[0] <= r_b_job;
        end
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        localparam logic [63:0] SBIT = 64'd1 << (2*SQ - 2 - 2*j);
        logic [63:0] trial;
        assign trial = r_sr[j] + SBIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sj[j+1] <= r_sj[j];
                if (r_sx[j] >= trial) begin
                    r_sx[j+1] <= r_sx[j] - trial;
                    r_sr[j+1] <= (r_sr[j] >> 1) + SBIT;
                end else begin
                    r_sx[j+1] <= r_sx[j];
                    r_sr[j+1] <= r_sr[j] >> 1;
                end
            end
        end
    end

    // ---- unit vector divide setup
    logic [31:0]        rq_d;
    logic [2:0][24:0]   pmag_d;
    logic [2:0]         pneg_d;
    logic [2:0][59:0]   nu_d;

    assign rq_d = r_sr[SQ][31:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pneg_d[i] = r_sj[SQ].p[i][24];
            pmag_d[i] = pneg_d[i] ? 25'(-r_sj[SQ].p[i]) : r_sj[SQ].p[i];
            nu_d[i]   = {pmag_d[i], 35'd0} + 60'(rq_d >> 1);
        end
    end

    logic [2:0][31:0]   r_ur  [0:U];
    logic [2:0][U-1:0]  r_ul  [0:U];
    logic [2:0][U-1:0]  r_uq  [0:U];
    logic [2:0]         r_un  [0:U];
    logic [31:0]        r_urq [0:U];
    mdf_pkg::t_ctx      r_uc  [0:U];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_ur[0][i] <= 32'(nu_d[i][59:U]);
                r_ul[0][i] <= nu_d[i][U-1:0];
            end
            r_uq[0]  <= '0;
            r_un[0]  <= pneg_d;
            r_urq[0] <= rq_d;
            r_uc[0]  <= r_sj[SQ].ctx;
        end
    end

    for (genvar k = 0; k < U; k++) begin : g_ud
        logic [2:0][32:0] ext;
        logic [2:0]       ge;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                ext[i] = {r_ur[k][i], r_ul[k][i][U-1]};
                ge[i]  = ext[i] >= {1'b0, r_urq[k]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_ur[k+1][i] <= ge[i] ? 32'(ext[i] - {1'b0, r_urq[k]}) : ext[i][31:0];
                    r_ul[k+1][i] <= {r_ul[k][i][U-2:0], 1'b0};
                    r_uq[k+1][i] <= {r_uq[k][i][U-2:0], ge[i]};
                end
                r_un[k+1]  <= r_un[k];
                r_urq[k+1] <= r_urq[k];
                r_uc[k+1]  <= r_uc[k];
            end
        end
    end

    // ---- stage E: signed u, dir*u, rq^2, moment scale
    logic signed [30:0] u_e  [3];
    logic signed [46:0] pr_e [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_e[i]  = r_un[U][i] ? -$signed({1'b0, r_uq[U][i]}) : $signed({1'b0, r_uq[U][i]});
            pr_e[i] = $signed(r_uc[U].dir[i]) * u_e[i];
        end
    end

    logic [2:0][30:0]   r_e_u;
    logic [2:0][46:0]   r_e_pr;
    logic [63:0]        r_e_rq2;
    logic [31:0]        r_e_rq;
    logic [43:0]        r_e_k;
    mdf_pkg::t_ctx      r_e_ctx;

    // ---- stage F: dot product sum, rq^3 partial products
    logic [2:0][30:0]   r_f_u;
    logic signed [48:0] r_f_dot;
    logic [63:0]        r_f_pl;
    logic [63:0]        r_f_ph;
    logic [43:0]        r_f_k;
    mdf_pkg::t_ctx      r_f_ctx;

    // ---- stage G: rounded u.d times three, rq^3
    logic [48:0]        dmag_g;
    logic [34:0]        drnd_g;
    logic signed [35:0] ud_g;
    logic [2:0][30:0]   r_g_u;
    logic signed [37:0] r_g_ud3;
    logic [95:0]        r_g_den;
    logic [43:0]        r_g_k;
    mdf_pkg::t_ctx      r_g_ctx;

    always_comb begin
        dmag_g = r_f_dot[48] ? 49'(-r_f_dot) : r_f_dot;
        drnd_g = 35'((dmag_g + 49'd8192) >> 14);
        ud_g   = r_f_dot[48] ? -$signed({1'b0, drnd_g}) : $signed({1'b0, drnd_g});
    end

    // ---- stage H: 3*ud*u
    logic signed [68:0] tp_h [3];
    logic [2:0][68:0]   r_h_tp;
    logic [43:0]        r_h_k;
    logic [95:0]        r_h_den;
    mdf_pkg::t_ctx      r_h_ctx;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tp_h[i] = r_g_ud3 * $signed(r_g_u[i]);
        end
    end

    // ---- stage I: v = round(tp / 2^28) - dir * 2^14
    logic [68:0]        tmag_i [3];
    logic [40:0]        trnd_i [3];
    logic [41:0]        t_i    [3];
    logic [42:0]        v_i    [3];
    logic [2:0][33:0]   r_i_vmag;
    logic [2:0]         r_i_vneg;
    logic [43:0]        r_i_k;
    logic [95:0]        r_i_den;
    logic               r_i_close;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tmag_i[i] = r_h_tp[i][68] ? 69'(-r_h_tp[i]) : r_h_tp[i];
            trnd_i[i] = 41'((tmag_i[i] + 69'd134217728) >> 28);
            t_i[i]    = r_h_tp[i][68] ? 42'(-{1'b0, trnd_i[i]}) : {1'b0, trnd_i[i]};
            v_i[i]    = {t_i[i][41], t_i[i]}
                      - {{13{r_h_ctx.dir[i][15]}}, r_h_ctx.dir[i], 14'd0};
        end
    end

    // ---- stage J: moment scale times |v|, two halves
    logic [2:0][60:0]   r_j_pl;
    logic [2:0][60:0]   r_j_ph;
    logic [2:0]         r_j_vneg;
    logic [95:0]        r_j_den;
    logic               r_j_close;

    // ---- stage K: rounding numerator and divisor
    logic [77:0]        num_k [3];
    logic [2:0][104:0]  r_k_np;
    logic [96:0]        r_k_dp;
    logic [2:0]         r_k_vneg;
    logic               r_k_close;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_k[i] = {r_j_ph[i], 17'd0} + 78'(r_j_pl[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e_u[i]  <= u_e[i];
                r_e_pr[i] <= pr_e[i];
            end
            r_e_rq2 <= 64'(r_urq[U]) * 64'(r_urq[U]);
            r_e_rq  <= r_urq[U];
            r_e_k   <= 44'(r_uc[U].moment) * mdf_pkg::MEGA;
            r_e_ctx <= r_uc[U];

            r_f_u   <= r_e_u;
            r_f_dot <= 49'($signed(r_e_pr[0])) + 49'($signed(r_e_pr[1]))
                     + 49'($signed(r_e_pr[2]));
            r_f_pl  <= 64'(r_e_rq2[31:0]) * 64'(r_e_rq);
            r_f_ph  <= 64'(r_e_rq2[63:32]) * 64'(r_e_rq);
            r_f_k   <= r_e_k;
            r_f_ctx <= r_e_ctx;

            r_g_u   <= r_f_u;
            r_g_ud3 <= {{2{ud_g[35]}}, ud_g} + {ud_g[35], ud_g, 1'b0};
            r_g_den <= {r_f_ph, 32'd0} + 96'(r_f_pl);
            r_g_k   <= r_f_k;
            r_g_ctx <= r_f_ctx;

            for (int i = 0; i < 3; i++) begin
                r_h_tp[i] <= tp_h[i];
            end
            r_h_k   <= r_g_k;
            r_h_den <= r_g_den;
            r_h_ctx <= r_g_ctx;

            for (int i = 0; i < 3; i++) begin
                r_i_vneg[i] <= v_i[i][42];
                r_i_vmag[i] <= v_i[i][42] ? 34'(-v_i[i]) : v_i[i][33:0];
            end
            r_i_k     <= r_h_k;
            r_i_den   <= r_h_den;
            r_i_close <= r_h_ctx.close;

            for (int i = 0; i < 3; i++) begin
                r_j_pl[i] <= 61'(r_i_k) * 61'(r_i_vmag[i][16:0]);
                r_j_ph[i] <= 61'(r_i_k) * 61'(r_i_vmag[i][33:17]);
            end
            r_j_vneg  <= r_i_vneg;
            r_j_den   <= r_i_den;
            r_j_close <= r_i_close;

            for (int i = 0; i < 3; i++) begin
                r_k_np[i] <= 105'({num_k[i], 26'd0}) + 105'(r_j_den);
            end
            r_k_dp    <= {r_j_den, 1'b0};
            r_k_vneg  <= r_j_vneg;
            r_k_close <= r_j_close;
        end
    end

    // ---- stage L and final divide, one quotient bit per stage
    logic [2:0][96:0]   r_fr [0:F];
    logic [2:0][F-1:0]  r_fl [0:F];
    logic [2:0][F-1:0]  r_fq [0:F];
    logic [2:0]         r_fs [0:F];
    logic [2:0]         r_fn [0:F];
    logic [96:0]        r_fd [0:F];
    logic               r_fc [0:F];
    logic [2:0]         sat_l;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_l[i] = 97'(r_k_np[i][104:F]) >= r_k_dp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_fr[0][i] <= sat_l[i] ? '0 : 97'(r_k_np[i][104:F]);
                r_fl[0][i] <= r_k_np[i][F-1:0];
            end
            r_fq[0] <= '0;
            r_fs[0] <= sat_l;
            r_fn[0] <= r_k_vneg;
            r_fd[0] <= r_k_dp;
            r_fc[0] <= r_k_close;
        end
    end

    for (genvar k = 0; k < F; k++) begin : g_fd
        logic [2:0][97:0] ext;
        logic [2:0]       ge;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                ext[i] = {r_fr[k][i], r_fl[k][i][F-1]};
                ge[i]  = ext[i] >= {1'b0, r_fd[k]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_fr[k+1][i] <= ge[i] ? 97'(ext[i] - {1'b0, r_fd[k]}) : ext[i][96:0];
                    r_fl[k+1][i] <= {r_fl[k][i][F-2:0], 1'b0};
                    r_fq[k+1][i] <= {r_fq[k][i][F-2:0], ge[i]};
                end
                r_fs[k+1] <= r_fs[k];
                r_fn[k+1] <= r_fn[k];
                r_fd[k+1] <= r_fd[k];
                r_fc[k+1] <= r_fc[k];
            end
        end
    end

    // ---- output: saturate, apply sign, zero the fields of a too_close item
    logic [39:0]         lim_o  [3];
    logic [39:0]         mag_o  [3];
    logic [39:0]         fld_o  [3];
    mdf_pkg::t_out_item  n_out;
    mdf_pkg::t_out_item  r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lim_o[i] = r_fn[F][i] ? mdf_pkg::FIELD_NEG_MAG : mdf_pkg::FIELD_POS_MAX;
            mag_o[i] = (r_fs[F][i] || (r_fq[F][i] > {1'b0, lim_o[i]}))
                     ? lim_o[i] : r_fq[F][i][39:0];
            fld_o[i] = r_fn[F][i] ? 40'(-mag_o[i]) : mag_o[i];
        end
        n_out.too_close = r_fc[F];
        n_out.field_x   = r_fc[F] ? '0 : fld_o[0];
        n_out.field_y   = r_fc[F] ? '0 : fld_o[1];
        n_out.field_z   = r_fc[F] ? '0 : fld_o[2];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

// ----- sv/mdf_checker.sv -----
// ----------------------------------------------------------------------------
// mdf_checker
// Port-level checks for the dipole field block, bound to the top level.
// ----------------------------------------------------------------------------
`include "magnetic_dipole_field_top_assert.svh"

module mdf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input mdf_pkg::t_in_item  i_item,
    input logic               empty,
    input logic               pop,
    input mdf_pkg::t_out_item o_item
);

    `MDF_ASSERT_NOW(a_close_zero, !empty && o_item.too_close, (o_item.field_x == '0) && (o_item.field_y == '0) && (o_item.field_z == '0), "too_close item with nonzero field")
    `MDF_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(o_item), "stalled result changed")
    `MDF_ASSERT_NOW(a_reset_clear, $rose(i_rst_n), empty && !full, "not empty after reset")
    `MDF_ASSERT_NXT(a_full_rise, !full && !push, !full, "full rose without an item")

endmodule

bind magnetic_dipole_field_top mdf_checker u_mdf_checker (.*);

// ----- tb/magnetic_dipole_field_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetic_dipole_field_chk
// Watches both queue ports of the dipole field block, computes the field each
// accepted item should give and compares every popped result against it.
// ----------------------------------------------------------------------------
module magnetic_dipole_field_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  mdf_pkg::t_in_item  i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  mdf_pkg::t_out_item i_res,
    output int                 o_errors,
    output int                 o_pending
);

    mdf_pkg::t_out_item field_q[$];

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        logic [63:0] m;
        m = ((v < 0 ? -v : v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [39:0] scale_axis(logic [23:0] mom, longint v, logic [63:0] rq);
        logic [129:0] den, num, q;
        logic [63:0]  mag;
        logic [39:0]  lim, m;
        mag = v < 0 ? -v : v;
        den = 130'(rq) * 130'(rq) * 130'(rq);
        num = (130'(mom) * 130'(1000000) * 130'(mag)) << 25;
        q = (2 * num + den) / (2 * den);
        lim = v < 0 ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
        m = (q > 130'(lim)) ? lim : q[39:0];
        return v < 0 ? -m : m;
    endfunction

    function automatic mdf_pkg::t_out_item dipole_field(mdf_pkg::t_in_item it);
        mdf_pkg::t_out_item f;
        longint      p[3], d[3], u[3];
        longint      dot, ud, t, v;
        logic [63:0] r2, rq, um;
        p[0] = longint'(it.magnet_x) - longint'(it.sensor_x);
        p[1] = longint'(it.magnet_y) - longint'(it.sensor_y);
        p[2] = longint'(it.magnet_z) - longint'(it.sensor_z);
        d[0] = longint'(it.dir_x);
        d[1] = longint'(it.dir_y);
        d[2] = longint'(it.dir_z);
        f = '0;
        r2 = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
        if (r2 == 0) begin
            f.too_close = 1'b1;
            return f;
        end
        rq = isqrt(r2 << 14);
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            um = (((p[i] < 0 ? -p[i] : p[i]) << 35) + (rq >> 1)) / rq;
            u[i] = p[i] < 0 ? -longint'(um) : longint'(um);
            dot += d[i] * u[i];
        end
        ud = rnd_shift(dot, 14);
        for (int i = 0; i < 3; i++) begin
            t = rnd_shift(3 * ud * u[i], 28);
            v = t - d[i] * 16384;
            case (i)
                0: f.field_x = scale_axis(it.moment, v, rq);
                1: f.field_y = scale_axis(it.moment, v, rq);
                default: f.field_z = scale_axis(it.moment, v, rq);
            endcase
        end
        return f;
    endfunction

    assign o_pending = field_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        mdf_pkg::t_out_item exp_f;
        int                 n_bad;
        n_bad = 0;
        if (i_rst_n && i_pop && !i_empty) begin
            if (field_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, i_res);
                n_bad++;
            end else begin
                exp_f = field_q.pop_front();
                if (i_res.field_x !== exp_f.field_x) begin
                    $display("%0t: field_x exp %h got %h", $time, exp_f.field_x, i_res.field_x);
                    n_bad++;
                end
                if (i_res.field_y !== exp_f.field_y) begin
                    $display("%0t: field_y exp %h got %h", $time, exp_f.field_y, i_res.field_y);
                    n_bad++;
                end
                if (i_res.field_z !== exp_f.field_z) begin
                    $display("%0t: field_z exp %h got %h", $time, exp_f.field_z, i_res.field_z);
                    n_bad++;
                end
                if (i_res.too_close !== exp_f.too_close) begin
                    $display("%0t: too_close exp %b got %b", $time, exp_f.too_close,
                             i_res.too_close);
                    n_bad++;
                end
            end
        end
        if (n_bad != 0) o_errors <= o_errors + n_bad;
        if (i_rst_n && i_push && !i_full) field_q.push_back(dipole_field(i_item));
    end

endmodule

// ----- tb/magnetic_dipole_field_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetic_dipole_field_top_tb
// Drives directed and random magnet/sensor items into the dipole field block
// under varying push and pop idling, including a long output stall, and
// reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module magnetic_dipole_field_top_tb;

    localparam int N_RAND = 500;
    localparam int LIMIT  = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               push, full, empty, pop;
    mdf_pkg::t_in_item  i_item;
    mdf_pkg::t_out_item o_item;
    int                 errors, pending;
    int                 tx_idle, rx_idle;
    int                 n_sent;
    int                 cycles;

    magnetic_dipole_field_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    magnetic_dipole_field_chk u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_full   (full),
        .i_item   (i_item),
        .i_empty  (empty),
        .i_pop    (pop),
        .i_res    (o_item),
        .o_errors (errors),
        .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver, with one long hold-off in the no-idle phase
    initial begin
        int  hold;
        bit  held;
        hold = 0;
        held = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= 450) begin
                held = 1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    task automatic send(mdf_pkg::t_in_item it);
        while ($urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        #1;
        while (full) @(negedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    function automatic mdf_pkg::t_in_item mk(int mx, int my, int mz, int mom,
                                             int dx, int dy, int dz, int sx, int sy, int sz);
        mdf_pkg::t_in_item it;
        it.magnet_x = 24'(mx);
        it.magnet_y = 24'(my);
        it.magnet_z = 24'(mz);
        it.moment   = 24'(mom);
        it.dir_x    = 16'(dx);
        it.dir_y    = 16'(dy);
        it.dir_z    = 16'(dz);
        it.sensor_x = 24'(sx);
        it.sensor_y = 24'(sy);
        it.sensor_z = 24'(sz);
        return it;
    endfunction

    function automatic mdf_pkg::t_in_item rand_item();
        mdf_pkg::t_in_item it;
        int                k;
        it = 216'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(99);
        if (k < 5) begin
            it.sensor_x = it.magnet_x;
            it.sensor_y = it.magnet_y;
            it.sensor_z = it.magnet_z;
        end else if (k < 65) begin
            it.sensor_x = it.magnet_x + $signed(24'($urandom_range(2 ** 18)) - 24'(2 ** 17));
            it.sensor_y = it.magnet_y + $signed(24'($urandom_range(2 ** 18)) - 24'(2 ** 17));
            it.sensor_z = it.magnet_z + $signed(24'($urandom_range(2 ** 18)) - 24'(2 ** 17));
            it.dir_x = $signed(16'($urandom_range(32768))) - 16'sd16384;
            it.dir_y = $signed(16'($urandom_range(32768))) - 16'sd16384;
            it.dir_z = $signed(16'($urandom_range(32768))) - 16'sd16384;
            it.moment = 24'($urandom_range(2 ** 16));
        end
        return it;
    endfunction

    initial begin
        push = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        n_sent = 0;
        tx_idle = 14;
        rx_idle = 77;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // coincident, far extremes, saturation, zero moment, odd directions
        send(mk(0, 0, 0, 4096, 16384, 0, 0, 0, 0, 0));
        send(mk(-8388608, 8388607, 12, 16777215, -32768, 32767, -1, -8388608, 8388607, 12));
        send(mk(8388607, 8388607, 8388607, 16777215, 32767, 32767, 32767,
                -8388608, -8388608, -8388608));
        send(mk(-8388608, -8388608, -8388608, 16777215, -32768, -32768, -32768,
                8388607, 8388607, 8388607));
        send(mk(1, 0, 0, 16777215, 16384, 0, 0, 0, 0, 0));
        send(mk(0, 0, 1, 16777215, 0, 0, -16384, 0, 0, 0));
        send(mk(0, -1, 0, 16777215, 0, 16384, 0, 0, 0, 0));
        send(mk(4096, 0, 0, 0, 16384, 0, 0, 0, 0, 0));
        send(mk(4096, 4096, 4096, 4096, 9459, 9459, 9459, 0, 0, 0));
        send(mk(0, 0, 40960, 4096, 0, 0, 16384, 0, 0, 0));
        send(mk(0, 0, 40960, 4096, 16384, 0, 0, 0, 0, 0));
        send(mk(-20480, 8192, 4096, 1000, -32768, 0, 0, 0, 0, 0));
        send(mk(100, 200, 300, 2048, 0, 0, 0, 100, 200, 300));
        send(mk(8388607, 0, 0, 16777215, 16384, 0, 0, -8388608, 0, 0));
        send(mk(123456, -654321, 7, 777777, 5000, -12000, 9000, -4000, 2000, 30000));
        send(mk(0, 0, 0, 1, 1, 1, 1, 0, 0, -1));

        for (int i = 0; i < N_RAND; i++) begin
            if (i == 180) begin
                tx_idle = 77;
                rx_idle = 14;
            end else if (i == 360) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            send(rand_item());
        end
        push <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (mdf_pkg::LAT + 20) @(negedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mdf_pkg.sv
sv/mdf_front.sv
sv/mdf_queue.sv
sv/mdf_back.sv
sv/magnetic_dipole_field_top.sv
sv/mdf_checker.sv
tb/magnetic_dipole_field_chk.sv
tb/magnetic_dipole_field_top_tb.sv
